@@ rtl/jit_pkg.sv @@
`timescale 1ns / 1ps

package jit_pkg;

	// Request and result field widths on the stream ports
	localparam int MODE_W     = 3;
	localparam int PID_W      = 22;
	localparam int JID_W      = 5;
	localparam int STATE_W    = 2;
	localparam int IN_DATA_W  = 32;
	localparam int OUT_DATA_W = 32;

	// Operation codes carried in the request tuser
	localparam logic [MODE_W-1:0] MODE_ADD  = 3'd0;
	localparam logic [MODE_W-1:0] MODE_DEL  = 3'd1;
	localparam logic [MODE_W-1:0] MODE_PID  = 3'd2;
	localparam logic [MODE_W-1:0] MODE_JID  = 3'd3;
	localparam logic [MODE_W-1:0] MODE_FG   = 3'd4;
	localparam logic [MODE_W-1:0] MODE_STOP = 3'd5;

	// Run states of a table entry
	localparam logic [STATE_W-1:0] ST_EMPTY = 2'd0;
	localparam logic [STATE_W-1:0] ST_FG    = 2'd1;
	localparam logic [STATE_W-1:0] ST_STOP  = 2'd3;

	// Control from the sequencer to the scan unit
	typedef struct packed {
		logic              clr;
		logic              vld;
		logic              ok;
		logic [MODE_W-1:0] mode;
	} scan_ctl_t;

	// Write control from the sequencer to the table memory
	typedef struct packed {
		logic set;
		logic clr;
	} wr_ctl_t;

endpackage

@@ rtl/jit_mem.sv @@
`timescale 1ns / 1ps

module jit_mem #(
	parameter int DEPTH = 16,
	parameter int PW    = 22,
	parameter int JW    = 5
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  jit_pkg::wr_ctl_t          wctl,
	input  logic [$clog2(DEPTH)-1:0]  waddr,
	input  logic [PW-1:0]             wpid,
	input  logic [JW-1:0]             wjid,
	input  logic [jit_pkg::STATE_W-1:0] wst,
	input  logic [$clog2(DEPTH)-1:0]  raddr,
	output logic                      rd_vld,
	output logic [PW-1:0]             rd_pid,
	output logic [JW-1:0]             rd_jid,
	output logic [jit_pkg::STATE_W-1:0] rd_st
);
	import jit_pkg::*;

	typedef struct packed {
		logic [PW-1:0]      pid;
		logic [JW-1:0]      jid;
		logic [STATE_W-1:0] st;
	} ent_t;

	ent_t             mem [DEPTH];
	ent_t             rdata_q;
	logic [DEPTH-1:0] valid_q;
	logic             rvld_q;

	// Entry payload: no reset, validity lives in valid_q
	always_ff @(posedge clk) begin
		if (wctl.set) begin
			mem[waddr] <= '{pid: wpid, jid: wjid, st: wst};
		end
	end

	always_ff @(posedge clk) begin
		rdata_q <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			rvld_q  <= 1'b0;
		end else begin
			if (wctl.set) begin
				valid_q[waddr] <= 1'b1;
			end else if (wctl.clr) begin
				valid_q[waddr] <= 1'b0;
			end
			rvld_q <= valid_q[raddr];
		end
	end

	// A free slot reads as all zero
	assign rd_vld = rvld_q;
	assign rd_pid = rvld_q ? rdata_q.pid : '0;
	assign rd_jid = rvld_q ? rdata_q.jid : '0;
	assign rd_st  = rvld_q ? rdata_q.st  : ST_EMPTY;

endmodule

@@ rtl/jit_scan.sv @@
`timescale 1ns / 1ps

module jit_scan #(
	parameter int DEPTH = 16,
	parameter int PW    = 22,
	parameter int JW    = 5
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  jit_pkg::scan_ctl_t          ctl,
	input  logic [$clog2(DEPTH)-1:0]    idx,
	input  logic                        e_vld,
	input  logic [PW-1:0]               e_pid,
	input  logic [JW-1:0]               e_jid,
	input  logic [jit_pkg::STATE_W-1:0] e_st,
	input  logic [PW-1:0]               req_pid,
	input  logic [jit_pkg::JID_W-1:0]   req_jid,
	output logic                        hit,
	output logic [$clog2(DEPTH)-1:0]    hit_idx,
	output logic [PW-1:0]               hit_pid,
	output logic [JW-1:0]               hit_jid,
	output logic [jit_pkg::STATE_W-1:0] hit_st,
	output logic [JW-1:0]               max_jid
);
	import jit_pkg::*;

	localparam int CW = (JW > JID_W) ? JW : JID_W;

	logic                     match;
	logic                     first;
	logic                     hit_q;
	logic [$clog2(DEPTH)-1:0] hit_idx_q;
	logic [PW-1:0]            hit_pid_q;
	logic [JW-1:0]            hit_jid_q;
	logic [STATE_W-1:0]       hit_st_q;
	logic [JW-1:0]            max_q;

	always_comb begin
		unique case (ctl.mode) inside
			MODE_ADD:           match = !e_vld;
			MODE_DEL, MODE_PID: match = (e_pid == req_pid);
			MODE_JID:           match = (CW'(e_jid) == CW'(req_jid));
			MODE_FG:            match = (e_st == ST_FG);
			MODE_STOP:          match = (e_st == ST_STOP);
			default:            match = 1'b0;
		endcase
		match = match && ctl.ok;
	end

	assign first = ctl.vld && match && !hit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q <= 1'b0;
			max_q <= '0;
		end else if (ctl.clr) begin
			hit_q <= 1'b0;
			max_q <= '0;
		end else if (ctl.vld) begin
			if (first) begin
				hit_q <= 1'b1;
			end else if (e_jid > max_q) begin
				// largest id among the entries that stay in the table
				max_q <= e_jid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (first) begin
			hit_idx_q <= idx;
			hit_pid_q <= e_pid;
			hit_jid_q <= e_jid;
			hit_st_q  <= e_st;
		end
	end

	assign hit     = hit_q;
	assign hit_idx = hit_idx_q;
	assign hit_pid = hit_pid_q;
	assign hit_jid = hit_jid_q;
	assign hit_st  = hit_st_q;
	assign max_jid = max_q;

endmodule

@@ rtl/job_id_table_core.sv @@
// Job table with job id allocation.
// Requests enter on the s_axis channel: tuser carries the operation (add, delete,
// lookup by process id, lookup by job id, find foreground, find stopped), tdata
// the process id, job id and run state. Each request gives exactly one item on
// the m_axis channel: tuser is the found flag, tdata the process id, job id and
// state of the entry that was added, deleted or matched, all zero on a miss.
// Every request sweeps the whole table through the registered read port of the
// table memory, one entry a cycle, then passes a drain state and commits its write
// in the commit state. The next request is taken only after that commit, so a new
// request is not accepted while one is in flight. The sweep is the limiting loop.
// Reset clears all valid bits of the table at once, so the table is empty and
// the next job id is one right after reset; no clearing pass is needed.
// The result register holds an item while m_axis_tready is low; a new request
// may still be accepted and swept, and it waits in its commit state until the
// result register frees up.
`timescale 1ns / 1ps

module job_id_table_core #(
	parameter int TABLE_DEPTH = 16,
	parameter int PID_BITS    = 22
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	// req_pid [21:0], req_jid [26:22], req_state [28:27], zero [31:29]
	input  logic [jit_pkg::IN_DATA_W-1:0]    s_axis_tdata,
	// mode [2:0]
	input  logic [jit_pkg::MODE_W-1:0]       s_axis_tuser,
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	// job_pid [21:0], job_id [26:22], job_state [28:27], zero [31:29]
	output logic [jit_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
	// found [0]
	output logic                             m_axis_tuser
);
	import jit_pkg::*;

	localparam int IW = $clog2(TABLE_DEPTH);
	localparam int JW = $clog2(TABLE_DEPTH + 1);

	localparam logic [1:0] S_IDLE   = 2'd0;
	localparam logic [1:0] S_SCAN   = 2'd1;
	localparam logic [1:0] S_DRAIN  = 2'd2;
	localparam logic [1:0] S_COMMIT = 2'd3;

	logic [1:0]          state_q;
	logic [MODE_W-1:0]   mode_q;
	logic [PID_BITS-1:0] pid_q;
	logic [JID_W-1:0]    jid_q;
	logic [STATE_W-1:0]  req_st_q;
	logic                ok_q;
	logic [IW-1:0]       cnt_q;
	logic                vld_s1;
	logic [IW-1:0]       idx_s1;
	logic [JW-1:0]       next_id_q;

	logic                out_vld_q;
	logic                out_found_q;
	logic [PID_W-1:0]    out_pid_q;
	logic [JID_W-1:0]    out_jid_q;
	logic [STATE_W-1:0]  out_st_q;

	logic                accept;
	logic                commit_go;
	logic [PID_BITS-1:0] in_pid;
	logic [JID_W-1:0]    in_jid;
	logic [STATE_W-1:0]  in_st;
	logic                in_ok;

	scan_ctl_t           sctl;
	wr_ctl_t             wctl;

	logic                rd_vld;
	logic [PID_BITS-1:0] rd_pid;
	logic [JW-1:0]       rd_jid;
	logic [STATE_W-1:0]  rd_st;

	logic                hit;
	logic [IW-1:0]       hit_idx;
	logic [PID_BITS-1:0] hit_pid;
	logic [JW-1:0]       hit_jid;
	logic [STATE_W-1:0]  hit_st;
	logic [JW-1:0]       max_jid;

	// Unpack the request; the process id is taken in its low PID_BITS bits
	assign in_pid = PID_BITS'(s_axis_tdata[PID_W-1:0]);
	assign in_jid = s_axis_tdata[PID_W +: JID_W];
	assign in_st  = s_axis_tdata[PID_W + JID_W +: STATE_W];

	// A zero id or an unknown operation misses every entry
	always_comb begin
		case (s_axis_tuser) inside
			MODE_ADD, MODE_DEL, MODE_PID: in_ok = (in_pid != '0);
			MODE_JID:                     in_ok = (in_jid != '0);
			MODE_FG, MODE_STOP:           in_ok = 1'b1;
			default:                      in_ok = 1'b0;
		endcase
	end

	assign s_axis_tready = (state_q == S_IDLE);
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign commit_go     = (state_q == S_COMMIT) && (!out_vld_q || m_axis_tready);

	// Sequencer: sweep every slot, then commit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			vld_s1  <= 1'b0;
		end else begin
			vld_s1 <= (state_q == S_SCAN);
			unique case (state_q)
				S_IDLE: begin
					cnt_q <= '0;
					if (accept) begin
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (cnt_q == IW'(TABLE_DEPTH - 1)) begin
						state_q <= S_DRAIN;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_DRAIN: begin
					// last read data is consumed by the scan unit this cycle
					state_q <= S_COMMIT;
				end
				S_COMMIT: begin
					if (commit_go) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= cnt_q;
		if (accept) begin
			mode_q   <= s_axis_tuser;
			pid_q    <= in_pid;
			jid_q    <= in_jid;
			req_st_q <= in_st;
			ok_q     <= in_ok;
		end
	end

	// Next job id: advance after an add, rebuild from the largest id after a delete
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			next_id_q <= JW'(1);
		end else if (commit_go && hit) begin
			if (mode_q == MODE_ADD) begin
				next_id_q <= (next_id_q == JW'(TABLE_DEPTH)) ? JW'(1) : next_id_q + 1'b1;
			end else if (mode_q == MODE_DEL) begin
				next_id_q <= (max_jid == JW'(TABLE_DEPTH)) ? JW'(1) : max_jid + 1'b1;
			end
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (commit_go) begin
			out_vld_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit_go) begin
			if (!hit) begin
				out_found_q <= 1'b0;
				out_pid_q   <= '0;
				out_jid_q   <= '0;
				out_st_q    <= ST_EMPTY;
			end else if (mode_q == MODE_ADD) begin
				out_found_q <= 1'b1;
				out_pid_q   <= PID_W'(pid_q);
				out_jid_q   <= JID_W'(next_id_q);
				out_st_q    <= req_st_q;
			end else begin
				// delete reports the entry as it was before clearing
				out_found_q <= 1'b1;
				out_pid_q   <= PID_W'(hit_pid);
				out_jid_q   <= JID_W'(hit_jid);
				out_st_q    <= hit_st;
			end
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tuser  = out_found_q;
	assign m_axis_tdata  = OUT_DATA_W'({out_st_q, out_jid_q, out_pid_q});

	assign sctl.clr  = accept;
	assign sctl.vld  = vld_s1;
	assign sctl.ok   = ok_q;
	assign sctl.mode = mode_q;

	assign wctl.set = commit_go && hit && (mode_q == MODE_ADD);
	assign wctl.clr = commit_go && hit && (mode_q == MODE_DEL);

	jit_mem #(
		.DEPTH (TABLE_DEPTH),
		.PW    (PID_BITS),
		.JW    (JW)
	) u_mem (
		.clk    (clk),
		.arst_n (arst_n),
		.wctl   (wctl),
		.waddr  (hit_idx),
		.wpid   (pid_q),
		.wjid   (next_id_q),
		.wst    (req_st_q),
		.raddr  (cnt_q),
		.rd_vld (rd_vld),
		.rd_pid (rd_pid),
		.rd_jid (rd_jid),
		.rd_st  (rd_st)
	);

	jit_scan #(
		.DEPTH (TABLE_DEPTH),
		.PW    (PID_BITS),
		.JW    (JW)
	) u_scan (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (sctl),
		.idx     (idx_s1),
		.e_vld   (rd_vld),
		.e_pid   (rd_pid),
		.e_jid   (rd_jid),
		.e_st    (rd_st),
		.req_pid (pid_q),
		.req_jid (jid_q),
		.hit     (hit),
		.hit_idx (hit_idx),
		.hit_pid (hit_pid),
		.hit_jid (hit_jid),
		.hit_st  (hit_st),
		.max_jid (max_jid)
	);

endmodule

@@ rtl/jit_checker.sv @@
`timescale 1ns / 1ps

module jit_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           s_axis_tvalid,
	input logic                           s_axis_tready,
	input logic                           m_axis_tvalid,
	input logic                           m_axis_tready,
	input logic [jit_pkg::OUT_DATA_W-1:0] m_axis_tdata,
	input logic                           m_axis_tuser
);
	import jit_pkg::*;

	// One request at a time: intake closes right after an item is taken
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("request taken while another is in flight");

	// A miss reports an all-zero entry
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0)
		else $error("miss with nonzero entry fields");

	// A hit always names an occupied entry, whose process id is never zero
	a_hit_pid: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[PID_W-1:0] != '0)
		else $error("hit with zero process id");

	// Hold a stalled result
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("result changed while stalled");

endmodule

bind job_id_table_core jit_checker u_jit_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser)
);
